>>> hw/rtl/alsm_pkg.sv
`default_nettype none

package alsm_pkg;

    // Width of one audio sample on the input port.
    localparam int SAMPLE_BITS = 24;
    localparam int SAMPLE_DOWN = (SAMPLE_BITS > 24) ? SAMPLE_BITS - 24 : 0;
    localparam int SAMPLE_UP   = (SAMPLE_BITS < 24) ? 24 - SAMPLE_BITS : 0;
    localparam int MAG_SHIFT   = 24 + SAMPLE_DOWN - SAMPLE_UP;

    localparam int MAX_BLOCK_DEF = 8192;
    // Sample count width, wide enough for the largest supported block length.
    localparam int CNT_W = 17;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam logic [23:0] LEVEL_MAX = 24'hFFFFFF;
    localparam logic [59:0] SUM_MAX   = {60{1'b1}};
    localparam logic [16:0] DB_FLOOR  = 17'd30720;
    localparam logic [26:0] DB_SCALE  = 27'd101008905;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_FLOOR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_GATE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_GATE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_RATE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_RATE   = 3'd4;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          block_end;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] peak_db;
        logic signed [15:0] rms_db;
        logic signed [15:0] noise_floor_db;
        logic [14:0]        snr_db;
        logic [31:0]        block_number;
    } t_out_item;

    typedef struct packed {
        logic [23:0] silence_floor;
        logic [23:0] noise_gate;
        logic [23:0] active_gate;
        logic [15:0] noise_rate;
        logic [15:0] active_rate;
    } t_cfg;

    // Summary of one finished block, handed from the front to the back.
    typedef struct packed {
        logic [23:0]      peak;
        logic [59:0]      sum;
        logic [CNT_W-1:0] cnt;
    } t_blk;

endpackage

`default_nettype wire

>>> hw/rtl/alsm_front.sv
`default_nettype none

module alsm_front #(
    parameter int MAX_BLOCK = alsm_pkg::MAX_BLOCK_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire alsm_pkg::t_in_item i_item,
    output logic                   o_push,
    output alsm_pkg::t_blk         o_blk
);
    import alsm_pkg::*;

    logic [CNT_W-1:0] r_cnt;
    logic             take;
    logic [SAMPLE_BITS:0] mag;
    logic [SAMPLE_BITS+24:0] wide;
    logic [23:0]      m24;

    logic             r_s1_vld, r_s1_take, r_s1_end;
    logic [23:0]      r_s1_m24;
    logic [CNT_W-1:0] r_s1_cnt;

    logic             r_s2_vld, r_s2_take, r_s2_end;
    logic [46:0]      r_s2_sq;
    logic [23:0]      r_s2_lvl;
    logic [CNT_W-1:0] r_s2_cnt;

    logic [23:0]      r_peak;
    logic [59:0]      r_sum;
    logic [24:0]      lvl2;
    logic [23:0]      peak_in, fpeak;
    logic [60:0]      sum61;
    logic [59:0]      fsum;

    assign take = r_cnt < CNT_W'(MAX_BLOCK);
    assign mag  = i_item.sample[SAMPLE_BITS-1]
                ? ({1'b1, {SAMPLE_BITS{1'b0}}} - {1'b0, i_item.sample})
                : {1'b0, i_item.sample};
    assign wide = {mag, 24'b0};
    assign m24  = 24'(wide >> MAG_SHIFT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_accept;
            r_s2_vld <= r_s1_vld;
            if (i_accept) begin
                if (i_item.block_end) begin
                    r_cnt <= '0;
                end else if (take) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_take <= take;
        r_s1_end  <= i_item.block_end;
        r_s1_m24  <= m24;
        r_s1_cnt  <= take ? r_cnt + 1'b1 : r_cnt;
        r_s2_take <= r_s1_take;
        r_s2_end  <= r_s1_end;
        r_s2_cnt  <= r_s1_cnt;
        r_s2_sq   <= 47'(r_s1_m24 * r_s1_m24);
        r_s2_lvl  <= lvl2[24] ? LEVEL_MAX : lvl2[23:0];
    end

    assign lvl2    = {r_s1_m24, 1'b0};
    assign peak_in = r_s2_take ? r_s2_lvl : 24'd0;
    assign fpeak   = (peak_in > r_peak) ? peak_in : r_peak;
    assign sum61   = {1'b0, r_sum} + (r_s2_take ? 61'(r_s2_sq) : 61'd0);
    assign fsum    = sum61[60] ? SUM_MAX : sum61[59:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
            r_sum  <= '0;
        end else if (r_s2_vld) begin
            r_peak <= r_s2_end ? 24'd0 : fpeak;
            r_sum  <= r_s2_end ? 60'd0 : fsum;
        end
    end

    assign o_push    = r_s2_vld && r_s2_end;
    assign o_blk.peak = fpeak;
    assign o_blk.sum  = fsum;
    assign o_blk.cnt  = r_s2_cnt;

endmodule

`default_nettype wire

>>> hw/rtl/alsm_queue.sv
`default_nettype none

module alsm_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire alsm_pkg::t_blk   i_blk,
    input  wire logic             i_pop,
    output alsm_pkg::t_blk        o_blk,
    output logic                  o_nonempty,
    output logic [alsm_pkg::QCNT_W-1:0] o_level
);
    import alsm_pkg::*;

    t_blk              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_level;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_blk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_level <= r_level + 1'b1;
                2'b01:   r_level <= r_level - 1'b1;
                default: r_level <= r_level;
            endcase
        end
    end

    assign o_blk      = r_mem[r_rd];
    assign o_nonempty = r_level != '0;
    assign o_level    = r_level;

endmodule

`default_nettype wire

>>> hw/rtl/alsm_back.sv
`default_nettype none

module alsm_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire alsm_pkg::t_cfg  i_cfg,
    input  wire logic            i_nonempty,
    input  wire alsm_pkg::t_blk  i_blk,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output alsm_pkg::t_out_item  o_item
);
    import alsm_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_DIV  = 11'b000_0000_0010,
        S_SQRT = 11'b000_0000_0100,
        S_TMUL = 11'b000_0000_1000,
        S_TADD = 11'b000_0001_0000,
        S_LSET = 11'b000_0010_0000,
        S_LMUL = 11'b000_0100_0000,
        S_LSQR = 11'b000_1000_0000,
        S_DMUL = 11'b001_0000_0000,
        S_DFIN = 11'b010_0000_0000,
        S_OUT  = 11'b100_0000_0000
    } t_state;

    t_state            r_state;
    logic [5:0]        r_step;
    logic [23:0]       r_peak;
    logic [CNT_W-1:0]  r_div;
    logic [CNT_W-1:0]  r_rem;
    logic [61:0]       r_dvd;
    logic [63:0]       r_v, r_res, r_bit;
    logic [23:0]       r_rms;
    logic [23:0]       r_noise, r_act;
    logic              r_tsel;
    logic [40:0]       r_p1;
    logic [39:0]       r_p2;
    logic [1:0]        r_lidx;
    logic [30:0]       r_m;
    logic [61:0]       r_prod;
    logic [4:0]        r_e;
    logic [15:0]       r_frac;
    logic [47:0]       r_dprod;
    logic signed [15:0] r_db_peak, r_db_rms, r_db_noise;
    logic [31:0]       r_blocks;

    logic [CNT_W:0]    rem2;
    logic              ge;
    logic [63:0]       sq_t;
    logic [23:0]       t_lvl;
    logic [15:0]       t_rate;
    logic [41:0]       t_acc;
    logic [23:0]       t_new;
    logic              t_gate;
    logic [23:0]       lx;
    logic [4:0]        le;
    logic [31:0]       lsq;
    logic [20:0]       ln;
    logic [16:0]       dd, dclamp;
    logic signed [15:0] db_val;
    logic signed [16:0] snr_raw;
    logic [14:0]       snr;

    assign rem2 = {r_rem, r_dvd[61]};
    assign ge   = rem2 >= {1'b0, r_div};
    assign sq_t = r_res + r_bit;

    assign t_lvl  = r_tsel ? r_act : r_noise;
    assign t_rate = r_tsel ? i_cfg.active_rate : i_cfg.noise_rate;
    assign t_acc  = 42'(r_p1) + 42'(r_p2) + 42'd32768;
    assign t_new  = t_acc[39:16];
    assign t_gate = r_tsel ? (r_rms >= i_cfg.active_gate)
                           : (r_rms > i_cfg.silence_floor && r_rms < i_cfg.noise_gate);

    always_comb begin
        case (r_lidx)
            2'd0:    lx = r_peak;
            2'd1:    lx = r_rms;
            2'd2:    lx = r_noise;
            default: lx = r_act;
        endcase
    end

    // Position of the leading one.
    always_comb begin
        le = '0;
        for (int i = 1; i < 24; i++) begin
            if (lx[i]) begin
                le = 5'(i);
            end
        end
    end

    assign lsq    = r_prod[61:30];
    assign ln     = 21'(24 * 65536) - {r_e, r_frac};
    assign dd     = r_dprod[48-1:32] + 17'(r_dprod[31]);
    assign dclamp = (dd > DB_FLOOR) ? DB_FLOOR : dd;
    // A zero level reads as the -120 dB floor.
    assign db_val = (lx == '0) ? -16'sd30720 : -$signed(16'(dclamp));
    assign snr_raw = 17'(db_val) - 17'(r_db_noise);
    assign snr    = snr_raw[16] ? 15'd0 : 15'(snr_raw);

    assign o_pop = (r_state == S_IDLE) && i_nonempty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_noise  <= '0;
            r_act    <= '0;
            r_blocks <= '0;
            o_valid  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_nonempty) begin
                        r_peak  <= i_blk.peak;
                        r_div   <= (i_blk.cnt == '0) ? CNT_W'(1) : i_blk.cnt;
                        r_dvd   <= {i_blk.sum, 2'b00};
                        r_rem   <= '0;
                        r_step  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= ge ? CNT_W'(rem2 - {1'b0, r_div}) : rem2[CNT_W-1:0];
                    r_dvd  <= {r_dvd[60:0], ge};
                    r_step <= r_step + 1'b1;
                    if (r_step == 6'd61) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_step == 6'd62) begin
                        r_v    <= {2'b00, r_dvd};
                        r_res  <= '0;
                        r_bit  <= 64'd1 << 62;
                        r_step <= '0;
                    end else begin
                        if (r_v >= sq_t) begin
                            r_v   <= r_v - sq_t;
                            r_res <= (r_res >> 1) + r_bit;
                        end else begin
                            r_res <= r_res >> 1;
                        end
                        r_bit <= r_bit >> 2;
                        if (r_bit == 64'd1) begin
                            r_tsel  <= 1'b0;
                            r_state <= S_TMUL;
                        end
                    end
                end
                S_TMUL: begin
                    if (r_tsel == 1'b0) begin
                        r_rms <= (r_res > 64'(LEVEL_MAX)) ? LEVEL_MAX : r_res[23:0];
                        r_p1  <= 41'(r_noise * (17'd65536 - 17'(i_cfg.noise_rate)));
                        r_p2  <= 40'(((r_res > 64'(LEVEL_MAX)) ? LEVEL_MAX : r_res[23:0])
                                 * i_cfg.noise_rate);
                    end else begin
                        r_p1 <= 41'(t_lvl * (17'd65536 - 17'(t_rate)));
                        r_p2 <= 40'(r_rms * t_rate);
                    end
                    r_state <= S_TADD;
                end
                S_TADD: begin
                    if (t_gate) begin
                        if (r_tsel) begin
                            r_act <= t_new;
                        end else begin
                            r_noise <= t_new;
                        end
                    end
                    if (r_tsel) begin
                        r_lidx  <= '0;
                        r_state <= S_LSET;
                    end else begin
                        r_tsel  <= 1'b1;
                        r_state <= S_TMUL;
                    end
                end
                S_LSET: begin
                    if (lx == '0) begin
                        r_state <= S_DFIN;
                    end else begin
                        r_e     <= le;
                        r_m     <= 31'({7'b0, lx} << (5'd30 - le));
                        r_frac  <= '0;
                        r_step  <= '0;
                        r_state <= S_LMUL;
                    end
                end
                S_LMUL: begin
                    r_prod  <= r_m * r_m;
                    r_state <= S_LSQR;
                end
                S_LSQR: begin
                    r_m    <= lsq[31] ? lsq[31:1] : lsq[30:0];
                    r_frac <= {r_frac[14:0], lsq[31]};
                    r_step <= r_step + 1'b1;
                    r_state <= (r_step == 6'd15) ? S_DMUL : S_LMUL;
                end
                S_DMUL: begin
                    r_dprod <= 48'(ln * DB_SCALE);
                    r_state <= S_DFIN;
                end
                S_DFIN: begin
                    r_state <= S_LSET;
                    r_lidx  <= r_lidx + 1'b1;
                    case (r_lidx)
                        2'd0: r_db_peak  <= db_val;
                        2'd1: r_db_rms   <= db_val;
                        2'd2: r_db_noise <= db_val;
                        default: begin
                            o_item.peak_db        <= r_db_peak;
                            o_item.rms_db         <= r_db_rms;
                            o_item.noise_floor_db <= r_db_noise;
                            o_item.snr_db         <= snr;
                            o_item.block_number   <= r_blocks + 1'b1;
                            r_blocks              <= r_blocks + 1'b1;
                            o_valid               <= 1'b1;
                            r_state               <= S_OUT;
                        end
                    endcase
                end
                S_OUT: begin
                    if (!i_stall) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // A zero level skips the log steps and lands in S_DFIN straight from S_LSET.
            if (r_state == S_LSET && lx == '0) begin
                r_dprod <= '0;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/audio_level_snr_meter.sv
`default_nettype none

// Audio level meter. Samples of all channels arrive pooled, one per request, and
// the request that carries block_end closes a block. While the input is not
// stalled, the front accepts one sample every clock cycle: it squares the
// magnitude and folds it into a saturating sum, a peak and a sample count, and
// at the end of a block it places a summary of the block in a four-entry queue.
// The back takes one summary at a time and produces one result per block: a
// 62-step restoring divide for the mean square, a 32-step square root for the
// RMS, two tracker updates, and four logarithms by sixteen squaring steps each.
// The input is stalled while two summaries wait in the queue, so blocks that
// the front closes faster than the back can process them throttle the input
// to the back's pace, while longer blocks stream at one sample per cycle.
// Results are held in an output register until taken. Configuration writes
// are always ready and take effect once registered, as the back reads them
// live while it works on a block; write them only while the meter is idle.
// All levels are in 1/256 dB, with -120 dB standing for silence.
module audio_level_snr_meter #(
    parameter int MAX_BLOCK = alsm_pkg::MAX_BLOCK_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire alsm_pkg::t_in_item            i_in_item,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output alsm_pkg::t_out_item                o_out_item,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [alsm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [alsm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import alsm_pkg::*;

    t_cfg              r_cfg;
    logic              push, pop, nonempty, accept;
    t_blk              front_blk, head_blk;
    logic [QCNT_W-1:0] level;

    // The configuration port never pushes back; an index past the last
    // register is dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.silence_floor <= 24'd17;
            r_cfg.noise_gate    <= 24'd16777;
            r_cfg.active_gate   <= 24'd53054;
            r_cfg.noise_rate    <= 16'd655;
            r_cfg.active_rate   <= 16'd3277;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SILENCE_FLOOR: r_cfg.silence_floor <= i_cfg_data;
                CFG_NOISE_GATE:    r_cfg.noise_gate    <= i_cfg_data;
                CFG_ACTIVE_GATE:   r_cfg.active_gate   <= i_cfg_data;
                CFG_NOISE_RATE:    r_cfg.noise_rate    <= i_cfg_data[15:0];
                CFG_ACTIVE_RATE:   r_cfg.active_rate   <= i_cfg_data[15:0];
                default:           r_cfg <= r_cfg;
            endcase
        end
    end

    // Two block ends may still be in the front's pipeline, so two free queue
    // entries are kept in reserve.
    assign o_in_stall = level >= QCNT_W'(QDEPTH - 2);
    assign accept     = i_in_valid && !o_in_stall;

    alsm_front #(.MAX_BLOCK(MAX_BLOCK)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_item),
        .o_push   (push),
        .o_blk    (front_blk)
    );

    alsm_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_blk      (front_blk),
        .i_pop      (pop),
        .o_blk      (head_blk),
        .o_nonempty (nonempty),
        .o_level    (level)
    );

    alsm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_nonempty (nonempty),
        .i_blk      (head_blk),
        .o_pop      (pop),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_item     (o_out_item)
    );

endmodule

`default_nettype wire
